### hdl/slsd_pkg.sv
// types, constants and codes shared by the deframer controller, datapath and top level
// no dependencies
`timescale 1ns / 1ps

package slsd_pkg;

    localparam int BUF_DEPTH  = 256;
    localparam int AW         = $clog2(BUF_DEPTH);
    localparam int CW         = AW + 1;
    localparam int MIN_LEN    = 5;
    localparam int CK_BYTES   = 2;
    localparam int PL_OFF     = 3;
    localparam logic [7:0] SYNC_RESET = 8'h55;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic       frame_found;
        logic [7:0] frame_cmd;
        logic [7:0] payload_len;
        logic [7:0] read_data;
    } t_out_beat;

    typedef enum logic [3:0] {
        RS_IDX, RS_SRC, RS_OFF, RS_OFF1, RS_OFFK, RS_CKLO, RS_CKHI, RS_OFF2, RS_PAY
    } t_rsel;

    typedef enum logic [1:0] {
        WS_NONE, WS_MOVE, WS_RX
    } t_wsel;

    typedef struct packed {
        logic  take;
        logic  idx_clr;
        logic  idx_inc;
        logic  skip_idx;
        logic  skip_one;
        logic  cnt_sub;
        logic  cnt_inc;
        logic  cnt_clr;
        logic  off_clr;
        logic  off_inc;
        logic  len_load;
        logic  sum_clr;
        logic  sum_acc;
        logic  lo_load;
        logic  frame_load;
        logic  fcmd_load;
        logic  rdata_load;
        logic  out_load;
        t_wsel wsel;
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic rd_ok;
        logic idx_eq_cnt;
        logic is_sync;
        logic skip_zero;
        logic mv_done;
        logic cnt_full;
        logic scan_end;
        logic len_bad;
        logic k_end;
        logic sum_ok;
    } t_stat;

endpackage

### hdl/slsd_datapath.sv
// deframer datapath: byte store, counters, running sum, config and result registers
// depends on slsd_pkg
`timescale 1ns / 1ps

module slsd_datapath
    import slsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  logic      i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_beat o_out_data
);

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rdata;
    logic [7:0]    r_sync;
    t_in_beat      r_item;
    logic [CW-1:0] r_cnt, r_idx, r_skip, r_off;
    logic [7:0]    r_len, r_k, r_lo;
    logic [15:0]   r_sum;
    logic [AW-1:0] r_fstart;
    logic [7:0]    r_flen;
    logic          r_res_found;
    logic [7:0]    r_res_cmd, r_res_plen, r_res_rdata;
    t_out_beat     r_out;

    logic [CW:0]   rd_wide;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [AW+1:0] pay_wide;
    logic [CW-1:0] cnt_left;

    assign pay_wide = (AW+2)'(r_fstart) + (AW+2)'(PL_OFF) + (AW+2)'(r_item.read_index);
    assign cnt_left = r_cnt - r_off;

    always_comb begin
        case (i_cmd.rsel)
            RS_IDX:  rd_wide = (CW+1)'(r_idx);
            RS_SRC:  rd_wide = (CW+1)'(r_idx) + (CW+1)'(r_skip);
            RS_OFF:  rd_wide = (CW+1)'(r_off);
            RS_OFF1: rd_wide = (CW+1)'(r_off) + (CW+1)'(1);
            RS_OFFK: rd_wide = (CW+1)'(r_off) + (CW+1)'(r_k);
            RS_CKLO: rd_wide = (CW+1)'(r_off) + (CW+1)'(r_len) - (CW+1)'(CK_BYTES);
            RS_CKHI: rd_wide = (CW+1)'(r_off) + (CW+1)'(r_len) - (CW+1)'(1);
            RS_OFF2: rd_wide = (CW+1)'(r_off) + (CW+1)'(2);
            RS_PAY:  rd_wide = (CW+1)'(pay_wide);
            default: rd_wide = '0;
        endcase
    end

    assign rd_addr = rd_wide[AW-1:0];
    assign wr_addr = (i_cmd.wsel == WS_MOVE) ? r_idx[AW-1:0] : r_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        case (i_cmd.wsel)
            WS_MOVE: r_mem[wr_addr] <= r_rdata;
            WS_RX:   r_mem[wr_addr] <= r_item.rx_byte;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= SYNC_RESET;
            r_cnt    <= '0;
            r_fstart <= '0;
            r_flen   <= '0;
        end else begin
            if (i_cfg_valid) r_sync <= i_cfg_data;
            if (i_cmd.cnt_sub)      r_cnt <= r_cnt - r_skip;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + CW'(1);
            else if (i_cmd.cnt_clr) r_cnt <= '0;
            if (i_cmd.frame_load) begin
                r_fstart <= r_off[AW-1:0];
                r_flen   <= r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item      <= i_in_data;
            r_res_found <= 1'b0;
            r_res_cmd   <= '0;
            r_res_plen  <= '0;
            r_res_rdata <= '0;
        end
        if (i_cmd.idx_clr)      r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
        if (i_cmd.skip_idx)      r_skip <= r_idx;
        else if (i_cmd.skip_one) r_skip <= CW'(1);
        if (i_cmd.off_clr)      r_off <= '0;
        else if (i_cmd.off_inc) r_off <= r_off + CW'(1);
        if (i_cmd.len_load) r_len <= r_rdata;
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
            r_k   <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= r_sum + 16'(r_rdata);
            r_k   <= r_k + 8'd1;
        end
        if (i_cmd.lo_load) r_lo <= r_rdata;
        if (i_cmd.fcmd_load) begin
            r_res_found <= 1'b1;
            r_res_cmd   <= r_rdata;
            r_res_plen  <= r_len - 8'(MIN_LEN);
        end
        if (i_cmd.rdata_load) r_res_rdata <= r_rdata;
        if (i_cmd.out_load) begin
            r_out.frame_found <= r_res_found;
            r_out.frame_cmd   <= r_res_cmd;
            r_out.payload_len <= r_res_plen;
            r_out.read_data   <= r_res_rdata;
        end
    end

    always_comb begin
        o_stat.is_read    = (r_item.cmd == CMD_READ);
        o_stat.rd_ok      = (r_flen >= 8'(MIN_LEN))
                            && (r_item.read_index < (r_flen - 8'(MIN_LEN)))
                            && (pay_wide < (AW+2)'(BUF_DEPTH));
        o_stat.idx_eq_cnt = (r_idx == r_cnt);
        o_stat.is_sync    = (r_rdata == r_sync);
        o_stat.skip_zero  = (r_skip == '0);
        o_stat.mv_done    = (r_idx == (r_cnt - r_skip));
        o_stat.cnt_full   = (r_cnt == CW'(BUF_DEPTH));
        o_stat.scan_end   = ((CW+1)'(r_off) + (CW+1)'(MIN_LEN)) > (CW+1)'(r_cnt);
        o_stat.len_bad    = (r_rdata < 8'(MIN_LEN)) || (cnt_left < CW'(r_rdata));
        o_stat.k_end      = (r_k == (r_len - 8'(CK_BYTES)));
        o_stat.sum_ok     = ({r_rdata, r_lo} == r_sum);
    end

    assign o_out_data = r_out;

endmodule

### hdl/slsd_controller.sv
// deframer sequencer: align, shift, append, frame scan and payload read steps
// depends on slsd_pkg
`timescale 1ns / 1ps

module slsd_controller
    import slsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [18:0] {
        S_IDLE    = 19'd1 << 0,
        S_DISP    = 19'd1 << 1,
        S_A_RD    = 19'd1 << 2,
        S_A_CMP   = 19'd1 << 3,
        S_MV_CHK  = 19'd1 << 4,
        S_MV_RD   = 19'd1 << 5,
        S_MV_WR   = 19'd1 << 6,
        S_POST    = 19'd1 << 7,
        S_WR      = 19'd1 << 8,
        S_SC_TEST = 19'd1 << 9,
        S_SC_SYNC = 19'd1 << 10,
        S_SC_LEN  = 19'd1 << 11,
        S_SUM_RD  = 19'd1 << 12,
        S_SUM_ACC = 19'd1 << 13,
        S_CK_LO   = 19'd1 << 14,
        S_CK_HI   = 19'd1 << 15,
        S_CMD     = 19'd1 << 16,
        S_RD_WAIT = 19'd1 << 17,
        S_OUT     = 19'd1 << 18
    } t_state;

    t_state r_state, n_state;
    logic   r_again, n_again;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_again = r_again;
        o_cmd   = '0;
        o_cmd.wsel = WS_NONE;
        o_cmd.rsel = RS_IDX;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_read) begin
                    if (i_stat.rd_ok) begin
                        o_cmd.rsel = RS_PAY;
                        n_state = S_RD_WAIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_again = 1'b0;
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    o_cmd.skip_idx = 1'b1;
                    n_state = S_MV_CHK;
                end else begin
                    o_cmd.rsel = RS_IDX;
                    n_state = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (i_stat.is_sync) begin
                    o_cmd.skip_idx = 1'b1;
                    n_state = S_MV_CHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_MV_CHK: begin
                o_cmd.idx_clr = 1'b1;
                n_state = i_stat.skip_zero ? S_POST : S_MV_RD;
            end
            S_MV_RD: begin
                if (i_stat.mv_done) begin
                    o_cmd.cnt_sub = 1'b1;
                    n_state = S_POST;
                end else begin
                    o_cmd.rsel = RS_SRC;
                    n_state = S_MV_WR;
                end
            end
            S_MV_WR: begin
                o_cmd.wsel = WS_MOVE;
                o_cmd.idx_inc = 1'b1;
                n_state = S_MV_RD;
            end
            S_POST: begin
                if (i_stat.cnt_full) begin
                    o_cmd.skip_one = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_again = 1'b1;
                    n_state = S_MV_RD;
                end else if (r_again) begin
                    o_cmd.idx_clr = 1'b1;
                    n_again = 1'b0;
                    n_state = S_A_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wsel = WS_RX;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.off_clr = 1'b1;
                n_state = S_SC_TEST;
            end
            S_SC_TEST: begin
                if (i_stat.scan_end) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rsel = RS_OFF;
                    n_state = S_SC_SYNC;
                end
            end
            S_SC_SYNC: begin
                if (i_stat.is_sync) begin
                    o_cmd.rsel = RS_OFF1;
                    n_state = S_SC_LEN;
                end else begin
                    o_cmd.off_inc = 1'b1;
                    n_state = S_SC_TEST;
                end
            end
            S_SC_LEN: begin
                if (i_stat.len_bad) begin
                    o_cmd.off_inc = 1'b1;
                    n_state = S_SC_TEST;
                end else begin
                    o_cmd.len_load = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_SUM_RD: begin
                if (i_stat.k_end) begin
                    o_cmd.rsel = RS_CKLO;
                    n_state = S_CK_LO;
                end else begin
                    o_cmd.rsel = RS_OFFK;
                    n_state = S_SUM_ACC;
                end
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state = S_SUM_RD;
            end
            S_CK_LO: begin
                o_cmd.lo_load = 1'b1;
                o_cmd.rsel = RS_CKHI;
                n_state = S_CK_HI;
            end
            S_CK_HI: begin
                if (i_stat.sum_ok) begin
                    o_cmd.frame_load = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.rsel = RS_OFF2;
                    n_state = S_CMD;
                end else begin
                    o_cmd.off_inc = 1'b1;
                    n_state = S_SC_TEST;
                end
            end
            S_CMD: begin
                o_cmd.fcmd_load = 1'b1;
                n_state = S_OUT;
            end
            S_RD_WAIT: begin
                o_cmd.rdata_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load)  n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else                 n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_again     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_again     <= n_again;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/sync_length_sum_deframer_unit.sv
// top level of the sync/length/checksum frame receiver
// depends on slsd_pkg, slsd_controller, slsd_datapath
//
// channel | direction | handshake          | payload
// in      | input     | i_in_valid/o_in_stall   | i_in_data (t_in_beat)
// out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_beat)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (sync byte)
//
// a read beat dispatches, reads the store if the index is valid, then outputs; a receive beat
// walks the byte store: alignment search and shift, one drop-oldest shift when full, append,
// then a scan in which each candidate offset re-sums its frame byte by byte
// one result per input beat; the output register lets the next beat enter while it waits
// synchronous active-low reset; the byte store itself is not cleared
`timescale 1ns / 1ps

module sync_length_sum_deframer_unit
    import slsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    slsd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    slsd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block idle right after taking a beat");

    a_found_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_found) |-> (o_out_data.read_data == 8'd0))
        else $error("frame result carries read data");

    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_found)
        |-> (o_out_data.frame_cmd == 8'd0 && o_out_data.payload_len == 8'd0))
        else $error("frame fields set without a frame");

endmodule
